// ===== rtl/trsw_pkg.sv =====
// shared constants, types and helper functions of the tristate remote switch transmitter
package trsw_pkg;

  localparam int PeriodWidth = 16;
  localparam int RepeatWidth = 4;
  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth = 16;
  localparam int TritCount = 12;
  localparam int WordWidth = 2 * TritCount;
  localparam int PosWidth = 4;
  localparam int PhaseWidth = 2;
  localparam int SegWidth = 5;

  localparam logic [CfgIndexWidth-1:0] REG_PERIOD_TICKS = 1'd0;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT_COUNT = 1'd1;

  localparam logic [PeriodWidth-1:0] PERIOD_TICKS_RESET = 16'd375;
  localparam logic [RepeatWidth-1:0] REPEAT_COUNT_RESET = 4'd4;

  localparam logic [PosWidth-1:0] SYNC_POS = 4'd12;
  localparam logic [SegWidth-1:0] SYNC_LOW_PERIODS = 5'd31;
  localparam logic [SegWidth-1:0] SHORT_PERIODS = 5'd1;
  localparam logic [SegWidth-1:0] LONG_PERIODS = 5'd3;

  localparam logic [1:0] TRIT_ZERO = 2'd0;
  localparam logic [1:0] TRIT_ONE = 2'd1;

  typedef logic [WordWidth-1:0] trit_word_t;

  // telegram: group bits, device bits, fixed 0 2 2, then the action
  function automatic trit_word_t pack_word(input logic [3:0] grp, input logic [3:0] dev,
                                           input logic act);
    trit_word_t w;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      w[2*i+1] = grp[i];
      w[2*i+9] = dev[i];
    end
    w[19] = 1'b1;
    w[21] = 1'b1;
    w[23] = act;
    return w;
  endfunction

  // base periods in one segment of a trit or of the sync
  function automatic logic [SegWidth-1:0] seg_len(input trit_word_t w,
                                                  input logic [PosWidth-1:0] pos,
                                                  input logic [PhaseWidth-1:0] ph);
    logic [1:0] t;
    logic [SegWidth-1:0] len;
    t = '0;
    for (int i = 0; i < TritCount; i++) begin
      if (pos == PosWidth'(i)) begin
        t = w[2*i +: 2];
      end
    end
    if (pos >= SYNC_POS) begin
      len = ph[0] ? SYNC_LOW_PERIODS : SHORT_PERIODS;
    end else if (t == TRIT_ZERO) begin
      len = ph[0] ? LONG_PERIODS : SHORT_PERIODS;
    end else if (t == TRIT_ONE) begin
      len = ph[0] ? SHORT_PERIODS : LONG_PERIODS;
    end else begin
      len = (ph == 2'd1 || ph == 2'd2) ? LONG_PERIODS : SHORT_PERIODS;
    end
    return len;
  endfunction

endpackage

// ===== rtl/trsw_if.sv =====
// item channels of the transmitter: command items in, pin results out
interface trsw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] group_index;
  logic [3:0] device_index;
  logic       switch_on;

  modport source (output valid, command, group_index, device_index, switch_on, input ready);
  modport sink (input valid, command, group_index, device_index, switch_on, output ready);
endinterface

interface trsw_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic frame_done;
  logic rejected;

  modport source (output valid, pin_level, busy_res, frame_done, rejected, input ready);
  modport sink (input valid, pin_level, busy_res, frame_done, rejected, output ready);
endinterface

// ===== rtl/tristate_remote_switch_transmitter_unit.sv =====
// top level: tristate remote switch telegram generator
//
// in_ch takes items that are either one time tick (command 0) or a send
// command (command 1) with group, device and on/off action. out_ch gives
// exactly one result per item: pin level, busy flag, end of telegram flag
// and a flag for a send that arrived while busy.
// The result of an item is registered: it is in the output register on the
// clock after it is accepted. One item is taken per cycle while out_ch does
// not stall; the state update for an item is a single combinational pass
// (16-bit tick compare, segment length lookup) between the state registers
// and the result register. When out_ch stalls, the held result stays and in_ch
// takes one more item only once the output register is free again.
// Reset (rst, synchronous) clears the state to idle, leaves no result valid
// and loads 375 ticks per base period and 4 repeats. The configuration port
// writes period_ticks (index 0) or repeat_count (index 1); a change while
// sending takes effect at once.
module tristate_remote_switch_transmitter_unit
  import trsw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  trsw_in_if.sink                  in_ch,
  trsw_out_if.source               out_ch
);

  logic [PeriodWidth-1:0] period_ticks;
  logic [RepeatWidth-1:0] repeat_count;

  trit_word_t             trit_word, trit_word_next;
  logic [PosWidth-1:0]    trit_position, trit_position_next;
  logic [PhaseWidth-1:0]  pulse_phase, pulse_phase_next;
  logic [SegWidth-1:0]    periods_left, periods_left_next;
  logic [PeriodWidth-1:0] tick_count, tick_count_next;
  logic [RepeatWidth-1:0] repeats_done, repeats_done_next;
  logic                   sending, sending_next;
  logic                   done, rej;

  logic                   out_valid;
  logic                   accept;
  logic [PeriodWidth-1:0] per, tick_inc;
  logic [SegWidth-1:0]    pl_dec;
  logic [RepeatWidth-1:0] rc, rd_inc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_TICKS_RESET;
      repeat_count <= REPEAT_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PERIOD_TICKS: period_ticks <= cfg_data;
        REG_REPEAT_COUNT: repeat_count <= cfg_data[RepeatWidth-1:0];
        default: ;
      endcase
    end
  end

  assign per = (period_ticks == '0) ? PeriodWidth'(1) : period_ticks;
  assign rc = (repeat_count == '0) ? RepeatWidth'(1) : repeat_count;
  assign tick_inc = tick_count + PeriodWidth'(1);
  assign pl_dec = (periods_left != '0) ? periods_left - SegWidth'(1) : '0;
  assign rd_inc = repeats_done + RepeatWidth'(1);

  always_comb begin
    trit_word_next = trit_word;
    trit_position_next = trit_position;
    pulse_phase_next = pulse_phase;
    periods_left_next = periods_left;
    tick_count_next = tick_count;
    repeats_done_next = repeats_done;
    sending_next = sending;
    done = 1'b0;
    rej = 1'b0;
    if (in_ch.command) begin
      if (sending) begin
        rej = 1'b1;
      end else begin
        trit_word_next = pack_word(in_ch.group_index, in_ch.device_index, in_ch.switch_on);
        trit_position_next = '0;
        pulse_phase_next = '0;
        tick_count_next = '0;
        repeats_done_next = '0;
        sending_next = 1'b1;
        periods_left_next = seg_len(trit_word_next, '0, '0);
      end
    end else if (sending) begin
      tick_count_next = tick_inc;
      if (tick_inc >= per || tick_inc == '0) begin
        tick_count_next = '0;
        periods_left_next = pl_dec;
        if (pl_dec == '0) begin
          if (trit_position < SYNC_POS) begin
            if (pulse_phase == 2'd3) begin
              pulse_phase_next = '0;
              trit_position_next = trit_position + PosWidth'(1);
            end else begin
              pulse_phase_next = pulse_phase + PhaseWidth'(1);
            end
          end else if (pulse_phase == '0) begin
            pulse_phase_next = 2'd1;
          end else begin
            repeats_done_next = rd_inc;
            pulse_phase_next = '0;
            trit_position_next = '0;
            if (rd_inc >= rc || rd_inc == '0) begin
              sending_next = 1'b0;
              done = 1'b1;
            end
          end
          periods_left_next = sending_next
                              ? seg_len(trit_word, trit_position_next, pulse_phase_next)
                              : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trit_word <= '0;
      trit_position <= '0;
      pulse_phase <= '0;
      periods_left <= '0;
      tick_count <= '0;
      repeats_done <= '0;
      sending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        trit_word <= trit_word_next;
        trit_position <= trit_position_next;
        pulse_phase <= pulse_phase_next;
        periods_left <= periods_left_next;
        tick_count <= tick_count_next;
        repeats_done <= repeats_done_next;
        sending <= sending_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.pin_level <= sending_next && !pulse_phase_next[0];
      out_ch.busy_res <= sending_next;
      out_ch.frame_done <= done;
      out_ch.rejected <= rej;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/trsw_checker.sv =====
// port-level checks of the transmitter and their binding to the top level
module trsw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pin_level,
  input logic busy_res,
  input logic frame_done,
  input logic rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !busy_res && !pin_level)
    else $error("end of telegram while still sending");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res && !frame_done)
    else $error("send rejected while idle");

  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && pin_level |-> busy_res)
    else $error("pin high while idle");

endmodule

bind tristate_remote_switch_transmitter_unit trsw_checker u_trsw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pin_level  (out_ch.pin_level),
  .busy_res   (out_ch.busy_res),
  .frame_done (out_ch.frame_done),
  .rejected   (out_ch.rejected)
);

// ===== tb/sv/trsw_check_pkg.sv =====
// pin level predictor and result scoreboard of the tristate remote switch testbench
package trsw_check_pkg;
  import trsw_pkg::*;

  localparam logic [1:0] TRIT_TWO = 2'd2;
  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } pin_result_t;

  class telegram_scoreboard;
    pin_result_t expected_pins[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned telegrams_finished;
    int unsigned sends_turned_away;

    logic [PeriodWidth-1:0] period_ticks;
    logic [RepeatWidth-1:0] repeat_count;
    trit_word_t             word;
    logic [PosWidth-1:0]    trit_pos;
    logic [PhaseWidth-1:0]  phase;
    logic [SegWidth-1:0]    periods_left;
    logic [PeriodWidth-1:0] tick_count;
    logic [RepeatWidth-1:0] repeats_done;
    logic                   sending;

    function new();
      period_ticks = PERIOD_TICKS_RESET;
      repeat_count = REPEAT_COUNT_RESET;
      word = '0;
      trit_pos = '0;
      phase = '0;
      periods_left = '0;
      tick_count = '0;
      repeats_done = '0;
      sending = 1'b0;
      mismatches = 0;
      results_seen = 0;
      telegrams_finished = 0;
      sends_turned_away = 0;
    endfunction

    function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
      if (idx == REG_PERIOD_TICKS) begin
        period_ticks = value[PeriodWidth-1:0];
      end else if (idx == REG_REPEAT_COUNT) begin
        repeat_count = value[RepeatWidth-1:0];
      end
    endfunction

    // base periods in the current segment; even phase high, odd phase low
    function logic [SegWidth-1:0] segment_periods();
      logic [1:0] trit;
      trit = 2'(word >> (2 * trit_pos));
      if (trit_pos >= SYNC_POS) begin
        return phase[0] ? SYNC_LOW_PERIODS : SHORT_PERIODS;
      end
      case (trit)
        TRIT_ZERO: return phase[0] ? LONG_PERIODS : SHORT_PERIODS;
        TRIT_ONE:  return phase[0] ? SHORT_PERIODS : LONG_PERIODS;
        default:   return (phase == 2'd1 || phase == 2'd2) ? LONG_PERIODS : SHORT_PERIODS;
      endcase
    endfunction

    function void predict_pin_step(logic command, logic [3:0] grp, logic [3:0] dev,
                                   logic act);
      pin_result_t r;
      logic [PeriodWidth-1:0] per;
      logic [RepeatWidth-1:0] reps_needed;
      r = '0;
      per = (period_ticks == '0) ? PeriodWidth'(1) : period_ticks;
      reps_needed = (repeat_count == '0) ? RepeatWidth'(1) : repeat_count;
      if (command) begin
        if (sending) begin
          r.rejected = 1'b1;
          sends_turned_away++;
        end else begin
          word = '0;
          for (int i = 0; i < 4; i++) begin
            word[2*i +: 2] = grp[i] ? TRIT_TWO : TRIT_ZERO;
            word[2*(i+4) +: 2] = dev[i] ? TRIT_TWO : TRIT_ZERO;
          end
          word[2*8 +: 2] = TRIT_ZERO;
          word[2*9 +: 2] = TRIT_TWO;
          word[2*10 +: 2] = TRIT_TWO;
          word[2*11 +: 2] = act ? TRIT_TWO : TRIT_ZERO;
          trit_pos = '0;
          phase = '0;
          tick_count = '0;
          repeats_done = '0;
          sending = 1'b1;
          periods_left = segment_periods();
        end
      end else if (sending) begin
        tick_count = tick_count + 1'b1;
        if (tick_count >= per || tick_count == '0) begin
          tick_count = '0;
          periods_left = (periods_left != '0) ? periods_left - 1'b1 : '0;
          if (periods_left == '0) begin
            if (trit_pos < SYNC_POS) begin
              if (phase == 2'd3) begin
                phase = '0;
                trit_pos = trit_pos + 1'b1;
              end else begin
                phase = phase + 1'b1;
              end
            end else if (phase == '0) begin
              phase = 2'd1;
            end else begin
              repeats_done = repeats_done + 1'b1;
              phase = '0;
              trit_pos = '0;
              if (repeats_done >= reps_needed || repeats_done == '0) begin
                sending = 1'b0;
                r.frame_done = 1'b1;
                telegrams_finished++;
              end
            end
            periods_left = sending ? segment_periods() : '0;
          end
        end
      end
      r.pin_level = sending && !phase[0];
      r.busy_res = sending;
      expected_pins.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PrintCap) begin
        $display("mismatch at result %0d: %s", results_seen, msg);
      end
      mismatches++;
    endtask

    task check_pin_result(pin_result_t got);
      pin_result_t want;
      results_seen++;
      if (expected_pins.size() == 0) begin
        report_mismatch("result with no item waiting");
        return;
      end
      want = expected_pins.pop_front();
      if (got.pin_level !== want.pin_level) begin
        report_mismatch($sformatf("pin_level %b, want %b", got.pin_level, want.pin_level));
      end
      if (got.busy_res !== want.busy_res) begin
        report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
      end
      if (got.frame_done !== want.frame_done) begin
        report_mismatch($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
      end
      if (got.rejected !== want.rejected) begin
        report_mismatch($sformatf("rejected %b, want %b", got.rejected, want.rejected));
      end
    endtask
  endclass

endpackage

// ===== tb/sv/tristate_remote_switch_transmitter_unit_tb.sv =====
// top of the tristate remote switch testbench: clock, reset, item drivers and checks
module tristate_remote_switch_transmitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trsw_pkg::*;
  import trsw_check_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  int unsigned              src_idle_pct = 0;
  int unsigned              sink_stall_pct = 0;
  int unsigned              items_sent = 0;
  telegram_scoreboard       sb;

  trsw_in_if  in_ch ();
  trsw_out_if out_ch ();

  tristate_remote_switch_transmitter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    pin_result_t got;
    got = {out_ch.pin_level, out_ch.busy_res, out_ch.frame_done, out_ch.rejected};
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_pin_result(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no item moved for %0d cycles", QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic put_item(input logic command, input logic [3:0] grp,
                          input logic [3:0] dev, input logic act);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.command = 1'($urandom_range(1));
      in_ch.group_index = 4'($urandom_range(15));
      in_ch.device_index = 4'($urandom_range(15));
      in_ch.switch_on = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = command;
    in_ch.group_index = grp;
    in_ch.device_index = dev;
    in_ch.switch_on = act;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_pin_step(command, grp, dev, act);
    items_sent++;
  endtask

  task automatic put_random(input logic command);
    put_item(command, 4'($urandom_range(15)), 4'($urandom_range(15)),
             1'($urandom_range(1)));
  endtask

  // lets every expected result out before a register write
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // mostly whole telegrams, with the odd send while busy and idle tick
  task automatic run_phase(input logic [CfgDataWidth-1:0] period,
                           input logic [CfgDataWidth-1:0] repeats,
                           input int unsigned busy_items,
                           input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned useful;
    useful = 0;
    drain();
    write_reg(REG_PERIOD_TICKS, period);
    write_reg(REG_REPEAT_COUNT, repeats);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    while (useful < busy_items) begin
      if (sb.sending) begin
        if ($urandom_range(99) < 3) begin
          put_random(1'b1);
        end else begin
          put_random(1'b0);
          useful++;
        end
      end else if ($urandom_range(99) < 85) begin
        put_random(1'b1);
        useful++;
      end else begin
        put_random(1'b0);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_PERIOD_TICKS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.group_index = '0;
    in_ch.device_index = '0;
    in_ch.switch_on = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle tick, send, send while busy, ticks through the first trits
    write_reg(REG_PERIOD_TICKS, 16'd1);
    write_reg(REG_REPEAT_COUNT, 16'd1);
    put_item(1'b0, 4'd15, 4'd15, 1'b1);
    put_item(1'b1, 4'd15, 4'd0, 1'b1);
    put_item(1'b1, 4'd0, 4'd15, 1'b0);
    repeat (9) put_item(1'b0, 4'd0, 4'd0, 1'b0);
    put_item(1'b1, 4'd15, 4'd15, 1'b1);
    repeat (8) put_item(1'b0, 4'd15, 4'd15, 1'b1);

    run_phase(16'd1, 16'd1, 250, 0, 0);
    run_phase(16'd0, 16'd0, 250, 70, 0);
    run_phase(16'd2, 16'd1, 300, 0, 70);
    run_phase(16'd1, 16'd2, 300, 31, 31);
    run_phase(16'd65535, 16'd15, 150, 0, 0);
    run_phase(16'd2, 16'd1, 250, 70, 0);
    run_phase(16'd1, 16'd3, 250, 0, 70);
    run_phase(16'd0, 16'd1, 200, 31, 31);
    drain();

    $display("%0d items, %0d results checked, %0d telegrams finished, %0d sends turned away",
             items_sent, sb.results_seen, sb.telegrams_finished, sb.sends_turned_away);
    $display("periods from 0 to 65535 ticks, repeats from 0 to 15, idling and stalls on both sides");
    if (sb.mismatches == 0 && sb.expected_pins.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
